@@ rtl/core/scpwm_pkg.sv @@
// ----------------------------------------------------------------------------
// scpwm_pkg
// Types, register map and reset values shared by the sixteen-channel PWM
// register block and its checker.
// ----------------------------------------------------------------------------
package scpwm_pkg;

  localparam int CHANNELS      = 16;
  localparam int COUNT_BITS    = 12;
  localparam int NUM_CHAN_REGS = 64;
  localparam int CHAN_IDX_W    = 6;
  localparam int OUT_BITS      = 16;

  // Item kinds.
  localparam logic [1:0] KIND_SET_PTR = 2'd0;
  localparam logic [1:0] KIND_WRITE   = 2'd1;
  localparam logic [1:0] KIND_READ    = 2'd2;
  localparam logic [1:0] KIND_TICK    = 2'd3;

  // Register map.
  localparam logic [7:0] ADDR_MODE_ONE  = 8'h00;
  localparam logic [7:0] ADDR_MODE_TWO  = 8'h01;
  localparam logic [7:0] ADDR_SUB_FIRST = 8'h02;
  localparam logic [7:0] ADDR_SUB_LAST  = 8'h05;
  localparam logic [7:0] ADDR_CHAN_BASE = 8'h06;
  localparam logic [7:0] ADDR_CHAN_END  = 8'h46;
  localparam logic [7:0] ADDR_BC_FIRST  = 8'hFA;
  localparam logic [7:0] ADDR_BC_LAST   = 8'hFD;
  localparam logic [7:0] ADDR_PRESCALE  = 8'hFE;

  // Bit positions.
  localparam int SLEEP_BIT    = 4;
  localparam int AUTO_INC_BIT = 5;
  localparam int INVERT_BIT   = 4;
  localparam int FULL_BIT     = 4;

  // Reset values.
  localparam logic [7:0] MODE_ONE_RST   = 8'b0001_0001;
  localparam logic [7:0] MODE_TWO_RST   = 8'b0000_0100;
  localparam logic [7:0] PRESCALE_RST   = 8'b0001_1110;
  localparam logic [7:0] OFF_HIGH_RST   = 8'h10;
  localparam logic [7:0] PRESCALE_MIN   = 8'd3;
  localparam logic [7:0] SUB_RST [4]    = '{8'hE2, 8'hE4, 8'hE8, 8'hE0};

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] reg_address;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [7:0]          read_data;
    logic [OUT_BITS-1:0] pwm_out;
    logic                period_start;
  } result_t;

endpackage

@@ rtl/core/sixteen_channel_pwm_register_block_unit.sv @@
// ----------------------------------------------------------------------------
// sixteen_channel_pwm_register_block_unit
// Register file and PWM engine of a sixteen-channel LED controller.
// ----------------------------------------------------------------------------
// Path: an accepted beat moves from the stage register to the result register.
// Throughput: one beat per cycle while the output drains; the register update
// happens at acceptance, the channel compares when the beat leaves the stage.
// Reset: synchronous rst restores all registers to their power-up values and
// empties the pipeline; no beat is accepted while rst is high.
module sixteen_channel_pwm_register_block_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  scpwm_pkg::item_t    item,
  output logic                result_valid,
  input  logic                result_ready,
  output scpwm_pkg::result_t  result
);
  import scpwm_pkg::*;

  logic [7:0]            mode_one;
  logic [7:0]            mode_two;
  logic [7:0]            sub_regs [4];
  logic [7:0]            chan_regs [NUM_CHAN_REGS];
  logic [7:0]            prescale;
  logic [7:0]            reg_pointer;
  logic [7:0]            tick_divider;
  logic [COUNT_BITS-1:0] pwm_counter;

  logic                  stage_valid;
  logic [7:0]            stage_rd;
  logic                  stage_wrap;

  logic                  accept;
  logic                  stage_move;
  logic                  in_chan;
  logic                  in_bcast;
  logic                  in_sub;
  logic [7:0]            chan_off;
  logic [7:0]            bc_off;
  logic [7:0]            sub_off;
  logic [CHAN_IDX_W-1:0] chan_idx;
  logic [1:0]            bc_idx;
  logic [1:0]            sub_idx;
  logic [7:0]            read_byte;
  logic                  auto_inc;
  logic                  div_done;
  logic                  tick_wrap;
  logic [7:0]            prescale_next;
  logic [OUT_BITS-1:0]   levels;

  assign stage_move = stage_valid && (!result_valid || result_ready);
  assign item_ready = !rst && (!stage_valid || !result_valid || result_ready);
  assign accept     = item_valid && item_ready;

  // Address decode at the register pointer.
  always_comb begin
    in_chan  = (reg_pointer >= ADDR_CHAN_BASE) && (reg_pointer < ADDR_CHAN_END);
    in_bcast = (reg_pointer >= ADDR_BC_FIRST) && (reg_pointer <= ADDR_BC_LAST);
    in_sub   = (reg_pointer >= ADDR_SUB_FIRST) && (reg_pointer <= ADDR_SUB_LAST);
    chan_off = reg_pointer - ADDR_CHAN_BASE;
    bc_off   = reg_pointer - ADDR_BC_FIRST;
    sub_off  = reg_pointer - ADDR_SUB_FIRST;
    chan_idx = chan_off[CHAN_IDX_W-1:0];
    bc_idx   = bc_off[1:0];
    sub_idx  = sub_off[1:0];

    if (reg_pointer == ADDR_MODE_ONE) begin
      read_byte = mode_one;
    end else if (reg_pointer == ADDR_MODE_TWO) begin
      read_byte = mode_two;
    end else if (in_sub) begin
      read_byte = sub_regs[sub_idx];
    end else if (in_chan) begin
      read_byte = chan_regs[chan_idx];
    end else if (reg_pointer == ADDR_PRESCALE) begin
      read_byte = prescale;
    end else begin
      read_byte = 8'h00;
    end

    // A write to MODE1 decides the increment with the new value.
    if (item.kind == KIND_WRITE && reg_pointer == ADDR_MODE_ONE) begin
      auto_inc = item.data_byte[AUTO_INC_BIT];
    end else begin
      auto_inc = mode_one[AUTO_INC_BIT];
    end

    prescale_next = (item.data_byte < PRESCALE_MIN) ? PRESCALE_MIN : item.data_byte;
    div_done      = tick_divider >= prescale;
    tick_wrap     = !mode_one[SLEEP_BIT] && div_done && (&pwm_counter);
  end

  // Register file, pointer and prescaler update at acceptance.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_one     <= MODE_ONE_RST;
      mode_two     <= MODE_TWO_RST;
      prescale     <= PRESCALE_RST;
      reg_pointer  <= 8'h00;
      tick_divider <= 8'h00;
      pwm_counter  <= '0;
      for (int i = 0; i < 4; i++) begin
        sub_regs[i] <= SUB_RST[i];
      end
      for (int i = 0; i < NUM_CHAN_REGS; i++) begin
        chan_regs[i] <= ((i % 4) == 3) ? OFF_HIGH_RST : 8'h00;
      end
    end else if (accept) begin
      case (item.kind)
        KIND_SET_PTR: begin
          reg_pointer <= item.reg_address;
        end
        KIND_WRITE: begin
          if (reg_pointer == ADDR_MODE_ONE) begin
            mode_one <= item.data_byte;
          end
          if (reg_pointer == ADDR_MODE_TWO) begin
            mode_two <= item.data_byte;
          end
          if (in_sub) begin
            sub_regs[sub_idx] <= item.data_byte;
          end
          if (reg_pointer == ADDR_PRESCALE && mode_one[SLEEP_BIT]) begin
            prescale <= prescale_next;
          end
          for (int i = 0; i < NUM_CHAN_REGS; i++) begin
            if ((in_chan && chan_idx == CHAN_IDX_W'(i)) ||
                (in_bcast && bc_idx == 2'(i % 4) && i < CHANNELS * 4)) begin
              chan_regs[i] <= item.data_byte;
            end
          end
          if (auto_inc) begin
            reg_pointer <= reg_pointer + 8'd1;
          end
        end
        KIND_READ: begin
          if (auto_inc) begin
            reg_pointer <= reg_pointer + 8'd1;
          end
        end
        KIND_TICK: begin
          if (!mode_one[SLEEP_BIT]) begin
            if (div_done) begin
              tick_divider <= 8'h00;
              pwm_counter  <= pwm_counter + COUNT_BITS'(1);
            end else begin
              tick_divider <= tick_divider + 8'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Channel levels from the registers as left by the beat in the stage.
  always_comb begin
    logic [11:0]           on_full;
    logic [11:0]           off_full;
    logic [COUNT_BITS-1:0] on_cnt;
    logic [COUNT_BITS-1:0] off_cnt;
    logic                  hi;
    levels = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      on_full  = {chan_regs[4*c+1][3:0], chan_regs[4*c]};
      off_full = {chan_regs[4*c+3][3:0], chan_regs[4*c+2]};
      on_cnt   = on_full[COUNT_BITS-1:0];
      off_cnt  = off_full[COUNT_BITS-1:0];
      if (chan_regs[4*c+3][FULL_BIT]) begin
        hi = 1'b0;
      end else if (chan_regs[4*c+1][FULL_BIT]) begin
        hi = 1'b1;
      end else if (on_cnt < off_cnt) begin
        hi = (pwm_counter >= on_cnt) && (pwm_counter < off_cnt);
      end else if (on_cnt > off_cnt) begin
        hi = (pwm_counter >= on_cnt) || (pwm_counter < off_cnt);
      end else begin
        hi = 1'b0;
      end
      levels[c] = hi ^ mode_two[INVERT_BIT];
    end
  end

  // Two-entry result path: the stage holds read data and wrap flag until the
  // levels are sampled into the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid  <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        stage_valid <= 1'b1;
      end else if (stage_move) begin
        stage_valid <= 1'b0;
      end
      if (stage_move) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_rd   <= (item.kind == KIND_READ) ? read_byte : 8'h00;
      stage_wrap <= (item.kind == KIND_TICK) && tick_wrap;
    end
    if (stage_move) begin
      result.read_data    <= stage_rd;
      result.pwm_out      <= levels;
      result.period_start <= stage_wrap;
    end
  end

endmodule

@@ rtl/core/scpwm_checker.sv @@
// ----------------------------------------------------------------------------
// scpwm_checker
// Port-level checks of the sixteen-channel PWM register block.
// ----------------------------------------------------------------------------
module scpwm_checker (
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_ready,
  input scpwm_pkg::item_t   item,
  input logic               result_valid,
  input logic               result_ready,
  input scpwm_pkg::result_t result
);
  import scpwm_pkg::*;

  // A stalled result beat holds its payload.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  // A fresh result always comes from a beat that passed the stage unstalled.
  a_rise_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(item_valid && item_ready, 2))
    else $error("result appeared without a matching input beat");

  // Input is held off only when both pipeline entries are full and stalled.
  a_ready_low: assert property (@(posedge clk) disable iff (rst)
    !rst && !item_ready |-> result_valid && !result_ready)
    else $error("input stalled while the output could drain");

endmodule

bind sixteen_channel_pwm_register_block_unit scpwm_checker u_scpwm_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .item         (item),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

@@ tb/sv/pwm_check_pkg.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pwm_check_pkg
// In-order scoreboard for the sixteen-channel PWM register block. It keeps a
// mirror of the register file, the prescaler and the PWM counter. It predicts
// the result of every accepted beat and compares each returned result with
// the oldest prediction, one field at a time.
// ----------------------------------------------------------------------------
package pwm_check_pkg;
  import scpwm_pkg::*;

  class pwm_result_scoreboard;
    logic [7:0]            mode_one;
    logic [7:0]            mode_two;
    logic [7:0]            sub_addr [4];
    logic [7:0]            chan_regs [NUM_CHAN_REGS];
    logic [7:0]            prescale;
    logic [7:0]            pointer;
    logic [7:0]            divider;
    logic [COUNT_BITS-1:0] pwm_count;
    result_t               pending_results [$];
    int                    errors;
    int                    checked;
    int                    periods;
    int                    ticks;
    int                    writes;
    int                    reads;

    function new();
      mode_one = MODE_ONE_RST;
      mode_two = MODE_TWO_RST;
      foreach (sub_addr[i]) sub_addr[i] = SUB_RST[i];
      foreach (chan_regs[i]) chan_regs[i] = (i % 4 == 3) ? OFF_HIGH_RST : 8'h00;
      prescale  = PRESCALE_RST;
      pointer   = '0;
      divider   = '0;
      pwm_count = '0;
      errors    = 0;
      checked   = 0;
      periods   = 0;
      ticks     = 0;
      writes    = 0;
      reads     = 0;
    endfunction

    // Applies one accepted beat to the mirror and queues the result it causes.
    function void predict_result(item_t beat);
      result_t               r;
      logic [7:0]            a;
      logic [COUNT_BITS-1:0] on_cnt;
      logic [COUNT_BITS-1:0] off_cnt;
      logic                  hi;
      r = '0;
      a = pointer;
      case (beat.kind)
        KIND_SET_PTR: pointer = beat.reg_address;
        KIND_WRITE: begin
          writes++;
          if (a == ADDR_MODE_ONE) begin
            mode_one = beat.data_byte;
          end else if (a == ADDR_MODE_TWO) begin
            mode_two = beat.data_byte;
          end else if (a >= ADDR_SUB_FIRST && a <= ADDR_SUB_LAST) begin
            sub_addr[a - ADDR_SUB_FIRST] = beat.data_byte;
          end else if (a >= ADDR_CHAN_BASE && a < ADDR_CHAN_END) begin
            chan_regs[a - ADDR_CHAN_BASE] = beat.data_byte;
          end else if (a >= ADDR_BC_FIRST && a <= ADDR_BC_LAST) begin
            for (int c = 0; c < CHANNELS; c++)
              chan_regs[c * 4 + int'(a - ADDR_BC_FIRST)] = beat.data_byte;
          end else if (a == ADDR_PRESCALE && mode_one[SLEEP_BIT]) begin
            prescale = (beat.data_byte < PRESCALE_MIN) ? PRESCALE_MIN : beat.data_byte;
          end
          // The mode byte just written already decides the increment.
          if (mode_one[AUTO_INC_BIT]) pointer++;
        end
        KIND_READ: begin
          reads++;
          if (a == ADDR_MODE_ONE) r.read_data = mode_one;
          else if (a == ADDR_MODE_TWO) r.read_data = mode_two;
          else if (a >= ADDR_SUB_FIRST && a <= ADDR_SUB_LAST)
            r.read_data = sub_addr[a - ADDR_SUB_FIRST];
          else if (a >= ADDR_CHAN_BASE && a < ADDR_CHAN_END)
            r.read_data = chan_regs[a - ADDR_CHAN_BASE];
          else if (a == ADDR_PRESCALE) r.read_data = prescale;
          if (mode_one[AUTO_INC_BIT]) pointer++;
        end
        KIND_TICK: begin
          ticks++;
          if (!mode_one[SLEEP_BIT]) begin
            // A divider left above a lowered prescale also rolls over here.
            if (divider >= prescale) begin
              divider = '0;
              pwm_count++;
              if (pwm_count == '0) begin
                r.period_start = 1'b1;
                periods++;
              end
            end else begin
              divider++;
            end
          end
        end
        default: ;
      endcase
      for (int c = 0; c < CHANNELS; c++) begin
        on_cnt  = COUNT_BITS'({chan_regs[4 * c + 1][3:0], chan_regs[4 * c]});
        off_cnt = COUNT_BITS'({chan_regs[4 * c + 3][3:0], chan_regs[4 * c + 2]});
        if (chan_regs[4 * c + 3][FULL_BIT]) hi = 1'b0;
        else if (chan_regs[4 * c + 1][FULL_BIT]) hi = 1'b1;
        else if (on_cnt < off_cnt) hi = (pwm_count >= on_cnt) && (pwm_count < off_cnt);
        else if (on_cnt > off_cnt) hi = (pwm_count >= on_cnt) || (pwm_count < off_cnt);
        else hi = 1'b0;
        r.pwm_out[c] = hi ^ mode_two[INVERT_BIT];
      end
      pending_results.push_back(r);
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= 10) $display("MISMATCH: %s", msg);
    endfunction

    function void check_result(result_t got);
      result_t want;
      string   diff;
      if (pending_results.size() == 0) begin
        note_error($sformatf("unexpected result %p with nothing predicted", got));
        return;
      end
      want = pending_results.pop_front();
      checked++;
      diff = "";
      if (got.read_data !== want.read_data)
        diff = {diff, $sformatf(" read_data exp %02h got %02h", want.read_data, got.read_data)};
      if (got.pwm_out !== want.pwm_out)
        diff = {diff, $sformatf(" pwm_out exp %04h got %04h", want.pwm_out, got.pwm_out)};
      if (got.period_start !== want.period_start)
        diff = {diff, $sformatf(" period_start exp %0b got %0b",
                                want.period_start, got.period_start)};
      if (diff != "") note_error($sformatf("result %0d:%s", checked, diff));
    endfunction
  endclass

endpackage

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sixteen_channel_pwm_register_block_unit. A directed
// pass hits prescale clamping and locking, pointer wrap, reserved and
// broadcast addresses, full-on and full-off flags and divider rollover. A
// short tick sweep over spread channels follows, then random register traffic
// and tick bursts under several idle and stall mixes, with one long output
// hold-off.
// ----------------------------------------------------------------------------
module tb;
  import scpwm_pkg::*;
  import pwm_check_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 400;
  localparam int SWEEP_TICKS  = 48;

  localparam logic [7:0] AUTO_INC_MASK   = 8'(1 << AUTO_INC_BIT);
  localparam logic [7:0] SLEEP_MASK      = 8'(1 << SLEEP_BIT);
  localparam logic [7:0] ASLEEP_AUTO_INC = MODE_ONE_RST | AUTO_INC_MASK;
  localparam logic [7:0] AWAKE_AUTO_INC  = ASLEEP_AUTO_INC & ~SLEEP_MASK;

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  logic    item_ready;
  item_t   item         = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  int   send_idle  = 0;
  int   recv_stall = 0;
  logic hold_start = 1'b0;
  logic hold_taken = 1'b0;
  int   hold_left  = 0;
  int   items_sent = 0;
  int   quiet      = 0;

  pwm_result_scoreboard sb = new();

  always #5 clk = ~clk;

  sixteen_channel_pwm_register_block_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // Result side: check each accepted beat, then choose the next ready level.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) sb.check_result(result);
    if (hold_start && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(0, 99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    if ((item_valid && item_ready) || (result_valid && result_ready)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("Watchdog: no beat for %0d cycles, %0d results outstanding",
               quiet, sb.pending_results.size());
      $display("sixteen_channel_pwm_register_block_unit test failed");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] kind, logic [7:0] addr, logic [7:0] data);
    item_t next_item;
    next_item = '{kind, addr, data};
    while ($urandom_range(0, 99) < send_idle) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item       <= next_item;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sb.predict_result(next_item);
    items_sent++;
  endtask

  task automatic set_reg(logic [7:0] addr, logic [7:0] data);
    send_item(KIND_SET_PTR, addr, 8'($urandom));
    send_item(KIND_WRITE, 8'($urandom), data);
  endtask

  // Writes MODE1, then the four count bytes of one channel. Unless spread is set,
  // the edges land close to the present counter so the next ticks cross them.
  task automatic program_channel(int c, bit spread);
    logic [7:0]  mode;
    logic [11:0] on_cnt;
    logic [11:0] off_cnt;
    mode = 8'($urandom) | AUTO_INC_MASK;
    mode[SLEEP_BIT] = ($urandom_range(0, 9) == 0);
    set_reg(ADDR_MODE_ONE, mode);
    on_cnt = spread ? 12'($urandom)
                    : 12'(sb.pwm_count) + 12'($urandom_range(0, 40)) - 12'd20;
    off_cnt = ($urandom_range(0, 3) == 0) ? 12'($urandom)
                                          : on_cnt + 12'($urandom_range(0, 60)) - 12'd10;
    send_item(KIND_SET_PTR, ADDR_CHAN_BASE + 8'(4 * c), 8'($urandom));
    send_item(KIND_WRITE, 8'($urandom), on_cnt[7:0]);
    send_item(KIND_WRITE, 8'($urandom),
              {3'($urandom), ($urandom_range(0, 4) == 0), on_cnt[11:8]});
    send_item(KIND_WRITE, 8'($urandom), off_cnt[7:0]);
    send_item(KIND_WRITE, 8'($urandom),
              {3'($urandom), ($urandom_range(0, 4) == 0), off_cnt[11:8]});
  endtask

  task automatic random_sequence();
    int         pick;
    logic [7:0] mode;
    logic [7:0] scale;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      repeat ($urandom_range(1, 24)) send_item(KIND_TICK, 8'($urandom), 8'($urandom));
    end else if (pick < 55) begin
      program_channel($urandom_range(0, CHANNELS - 1), $urandom_range(0, 3) == 0);
    end else if (pick < 63) begin
      send_item(KIND_SET_PTR, ADDR_BC_FIRST + 8'($urandom_range(0, 3)), 8'($urandom));
      repeat ($urandom_range(1, 4)) send_item(KIND_WRITE, 8'($urandom), 8'($urandom));
    end else if (pick < 75) begin
      send_item(KIND_SET_PTR,
                ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                            : 8'($urandom_range(0, ADDR_CHAN_END - 1)),
                8'($urandom));
      repeat ($urandom_range(1, 4)) send_item(KIND_READ, 8'($urandom), 8'($urandom));
    end else if (pick < 85) begin
      // Retune the prescaler: sleep, write it, optionally change mode two, wake.
      case ($urandom_range(0, 3))
        0:       scale = 8'($urandom_range(0, 3));
        1:       scale = 8'($urandom);
        default: scale = 8'($urandom_range(3, 12));
      endcase
      set_reg(ADDR_MODE_ONE, ASLEEP_AUTO_INC);
      set_reg(ADDR_PRESCALE, scale);
      if ($urandom_range(0, 1) == 1) set_reg(ADDR_MODE_TWO, 8'($urandom));
      mode = 8'($urandom) & ~SLEEP_MASK;
      set_reg(ADDR_MODE_ONE, mode);
    end else begin
      repeat ($urandom_range(1, 3)) send_item(2'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    int target;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Asleep after reset, so prescale takes writes and small values clamp.
    set_reg(ADDR_PRESCALE, 8'h00);
    send_item(KIND_READ, 8'h00, 8'h00);
    send_item(KIND_WRITE, 8'hFF, 8'hFF);
    send_item(KIND_TICK, 8'hFF, 8'h00);
    set_reg(ADDR_MODE_ONE, AWAKE_AUTO_INC);
    repeat (4) send_item(KIND_TICK, 8'h00, 8'hFF);
    // Awake: the prescale write is dropped.
    set_reg(ADDR_PRESCALE, 8'h00);
    set_reg(ADDR_MODE_ONE, ASLEEP_AUTO_INC);
    set_reg(ADDR_PRESCALE, 8'h02);
    // Pointer now sits on a reserved address and wraps to zero on the read.
    send_item(KIND_READ, 8'h00, 8'h00);
    send_item(KIND_READ, 8'h00, 8'h00);
    set_reg(ADDR_MODE_ONE, AWAKE_AUTO_INC);
    // The divider is above the new prescale, so this tick rolls it over.
    send_item(KIND_TICK, 8'h00, 8'h00);
    set_reg(ADDR_BC_FIRST + 8'd1, 8'h1F);
    send_item(KIND_READ, 8'h00, 8'h00);
    set_reg(ADDR_CHAN_END, 8'h55);
    // Full-off on channel zero overrides the broadcast full-on.
    set_reg(ADDR_CHAN_BASE + 8'd3, OFF_HIGH_RST);
    set_reg(ADDR_MODE_TWO, 8'hFF);
    send_item(KIND_TICK, 8'h00, 8'h00);

    // A short tick sweep at the fastest prescale with spread channels.
    send_idle = 10;
    recv_stall <= 10;
    for (int c = 0; c < CHANNELS; c++) program_channel(c, 1'b1);
    set_reg(ADDR_MODE_TWO, MODE_TWO_RST);
    set_reg(ADDR_MODE_ONE, ASLEEP_AUTO_INC);
    set_reg(ADDR_PRESCALE, PRESCALE_MIN);
    set_reg(ADDR_MODE_ONE, AWAKE_AUTO_INC);
    repeat (SWEEP_TICKS) send_item(KIND_TICK, 8'($urandom), 8'($urandom));

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin send_idle = 0;  recv_stall <= 0;  end
        1: begin send_idle = 63; recv_stall <= 0;  end
        2: begin send_idle = 0;  recv_stall <= 63; end
        3: begin send_idle = 10; recv_stall <= 10; end
        default: begin
          send_idle = 0;
          recv_stall <= 0;
          hold_start <= 1'b1;
        end
      endcase
      target = items_sent + RANDOM_ITEMS / 5;
      while (items_sent < target) random_sequence();
    end

    item_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d beats: %0d ticks, %0d writes, %0d reads, %0d full PWM periods.",
             items_sent, sb.ticks, sb.writes, sb.reads, sb.periods);
    $display("%0d results compared, %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("sixteen_channel_pwm_register_block_unit test passed");
    end else begin
      $display("sixteen_channel_pwm_register_block_unit test failed");
    end
    $finish;
  end

endmodule
